// ===== design/diff_drive_odometry_core_macros.svh =====
`ifndef DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH

// Clocked check, off while reset is asserted
`define DDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/ddo_pkg.sv =====
package ddo_pkg;

  localparam int unsigned CntW        = 5;
  localparam int unsigned MulLanes    = 3;
  localparam int unsigned CordicSteps = 24;

  localparam logic signed [32:0] CordicStart = 33'sd652032874;
  localparam logic [19:0]        UsPerSec    = 20'd1000000;

  localparam logic [1:0] RegMpc = 2'd0;
  localparam logic [1:0] RegApc = 2'd1;
  localparam logic [1:0] RegNeg = 2'd2;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_PREP = 10'b0000000100,
    S_ROT  = 10'b0000001000,
    S_SLD  = 10'b0000010000,
    S_SCL  = 10'b0000100000,
    S_STEP = 10'b0001000000,
    S_ACC  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  function automatic logic signed [33:0] cordic_atan(input logic [CntW-1:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:    r = 34'sd536870912;
      5'd1:    r = 34'sd316933406;
      5'd2:    r = 34'sd167458907;
      5'd3:    r = 34'sd85004756;
      5'd4:    r = 34'sd42667331;
      5'd5:    r = 34'sd21354465;
      5'd6:    r = 34'sd10679838;
      5'd7:    r = 34'sd5340245;
      5'd8:    r = 34'sd2670163;
      5'd9:    r = 34'sd1335087;
      5'd10:   r = 34'sd667544;
      5'd11:   r = 34'sd333772;
      5'd12:   r = 34'sd166886;
      5'd13:   r = 34'sd83443;
      5'd14:   r = 34'sd41722;
      5'd15:   r = 34'sd20861;
      5'd16:   r = 34'sd10430;
      5'd17:   r = 34'sd5215;
      5'd18:   r = 34'sd2608;
      5'd19:   r = 34'sd1304;
      5'd20:   r = 34'sd652;
      5'd21:   r = 34'sd326;
      5'd22:   r = 34'sd163;
      5'd23:   r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] div_result(input logic [31:0] q, input logic neg,
                                                    input logic ovf);
    logic [31:0] r;
    if (ovf) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!neg) begin
      r = q[31] ? 32'h7FFF_FFFF : q;
    end else begin
      r = (q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
    end
    return signed'(r);
  endfunction

endpackage

// ===== design/diff_drive_odometry_core.sv =====
// Differential-drive odometry from raw wheel encoder counts, fixed point.
// Input channel (in_valid_i/in_ready_o): opcode, left and right counts, elapsed us.
// Opcode 1 clears the stored counts and pose and returns an all-zero result.
// Output channel (out_valid_o/out_ready_i): pose, heading, per-step deltas, speeds.
// Config channel (cfg_valid_i/cfg_ready_o): always ready; index 0 meters per count,
// 1 angle per count, 2 turn negate. Write only while idle.
// An update runs a bit-serial multiply for wheel distances and turn, a setup step,
// 24 CORDIC rotations, a setup step, a bit-serial multiply for the step, a scaling
// step, accumulation, a restoring division for the speeds and the output load. With
// zero elapsed time the division is skipped.
// A clear goes straight from acceptance to the output load. One transaction is
// processed at a time; the next input is taken the cycle after the result has moved
// into the output register.
// A stalled receiver holds the result in the output register; the core may finish one
// more transaction internally and waits in its final state until the register frees.
// Reset clears the configuration to defaults, the stored counts and the pose.
module diff_drive_odometry_core
  import ddo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [31:0]        left_count_i,
  input  logic [31:0]        right_count_i,
  input  logic [31:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] travel_delta_o,
  output logic signed [31:0] step_dx_o,
  output logic signed [31:0] step_dy_o,
  output logic signed [31:0] turn_delta_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] turn_rate_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0] mpc_q, mpc_d, apc_q, apc_d;
  logic neg_q, neg_d;
  logic [31:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d, yaw_q, yaw_d;
  logic signed [31:0] x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic out_valid_q, out_valid_d;

  logic [31:0] dt_q, dt_d;
  logic zero_q, zero_d;
  logic signed [32:0] mul_a_q [MulLanes];
  logic signed [32:0] mul_a_d [MulLanes];
  logic signed [33:0] mul_hi_q [MulLanes];
  logic signed [33:0] mul_hi_d [MulLanes];
  logic [31:0] mul_lo_q [MulLanes];
  logic [31:0] mul_lo_d [MulLanes];
  logic signed [33:0] mul_sum [MulLanes];
  logic signed [31:0] travel_q, travel_d, dx_q, dx_d, dy_q, dy_d;
  logic [31:0] turn_q, turn_d;
  logic signed [32:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [33:0] cz_q, cz_d;
  logic flip_q, flip_d, cneg_q, cneg_d, sneg_q, sneg_d;
  logic [50:0] lin_num_q, lin_num_d;
  logic [34:0] rate_num_q, rate_num_d;
  logic lin_neg_q, lin_neg_d, rate_neg_q, rate_neg_d;
  logic lin_ovf_q, lin_ovf_d, rate_ovf_q, rate_ovf_d;
  logic [31:0] lin_rem_q, lin_rem_d, rate_rem_q, rate_rem_d;
  logic [31:0] lin_quo_q, lin_quo_d, rate_quo_q, rate_quo_d;

  logic signed [31:0] pos_x_q, pos_y_q, travel_o_q, dx_o_q, dy_o_q, turn_o_q;
  logic signed [31:0] lin_o_q, rate_o_q;
  logic [31:0] heading_q;
  logic out_load;

  logic in_acc, out_acc, clr_acc;
  logic signed [31:0] dl, dr;
  logic signed [32:0] diff;
  logic signed [65:0] prod0, prod1, prodx, prody;
  logic signed [50:0] wheel_sum;
  logic signed [49:0] travel_wide;
  logic [31:0] turn_new, phi, phi_adj;
  logic phi_flip;
  logic signed [32:0] xs, ys;
  logic signed [33:0] atan;
  logic [31:0] trav_mag, turn_mag;
  logic [51:0] lin_prod, rate_prod;
  logic signed [32:0] cx_mag, cy_mag;
  logic signed [32:0] x_sum, y_sum;
  logic [32:0] lin_r2, rate_r2;
  logic lin_ge, rate_ge;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign clr_acc     = in_acc && (opcode_e'(opcode_i) == OP_CLEAR);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int l = 0; l < MulLanes; l++) begin
      mul_sum[l] = mul_hi_q[l] + (mul_lo_q[l][0] ? {mul_a_q[l][32], mul_a_q[l]} : 34'sd0);
    end
  end

  always_comb begin
    dl          = signed'(left_count_i - prev_l_q);
    dr          = signed'(right_count_i - prev_r_q);
    diff        = {dr[31], dr} - {dl[31], dl};
    prod0       = {mul_hi_q[0], mul_lo_q[0]};
    prod1       = {mul_hi_q[1], mul_lo_q[1]};
    wheel_sum   = {prod0[65], prod0[65:16]} + {prod1[65], prod1[65:16]};
    travel_wide = wheel_sum[50:1];
    turn_new    = neg_q ? (32'd0 - mul_lo_q[2]) : mul_lo_q[2];
    phi         = yaw_q + {turn_new[31], turn_new[31:1]};
    phi_flip    = phi[31] ^ phi[30];
    phi_adj     = {phi[31] ^ phi_flip, phi[30:0]};
    xs          = cx_q >>> cnt_q;
    ys          = cy_q >>> cnt_q;
    atan        = cordic_atan(cnt_q);
    trav_mag    = travel_q[31] ? (32'd0 - travel_q) : travel_q;
    turn_mag    = turn_q[31] ? (32'd0 - turn_q) : turn_q;
    lin_prod    = 52'(trav_mag) * 52'(UsPerSec);
    rate_prod   = 52'(turn_mag) * 52'(UsPerSec);
    cx_mag      = cx_q[32] ? -cx_q : cx_q;
    cy_mag      = cy_q[32] ? -cy_q : cy_q;
    prodx       = cneg_q ? -prod0 : prod0;
    prody       = sneg_q ? -prod1 : prod1;
    x_sum       = {x_acc_q[31], x_acc_q} + {dx_q[31], dx_q};
    y_sum       = {y_acc_q[31], y_acc_q} + {dy_q[31], dy_q};
    lin_r2      = {lin_rem_q, lin_quo_q[31]};
    rate_r2     = {rate_rem_q, rate_quo_q[31]};
    lin_ge      = lin_r2 >= {1'b0, dt_q};
    rate_ge     = rate_r2 >= {1'b0, dt_q};
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mpc_d       = mpc_q;
    apc_d       = apc_q;
    neg_d       = neg_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    x_acc_d     = x_acc_q;
    y_acc_d     = y_acc_q;
    yaw_d       = yaw_q;
    out_valid_d = out_valid_q;
    dt_d        = dt_q;
    zero_d      = zero_q;
    mul_a_d     = mul_a_q;
    mul_hi_d    = mul_hi_q;
    mul_lo_d    = mul_lo_q;
    travel_d    = travel_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    turn_d      = turn_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    flip_d      = flip_q;
    cneg_d      = cneg_q;
    sneg_d      = sneg_q;
    lin_num_d   = lin_num_q;
    rate_num_d  = rate_num_q;
    lin_neg_d   = lin_neg_q;
    rate_neg_d  = rate_neg_q;
    lin_ovf_d   = lin_ovf_q;
    rate_ovf_d  = rate_ovf_q;
    lin_rem_d   = lin_rem_q;
    rate_rem_d  = rate_rem_q;
    lin_quo_d   = lin_quo_q;
    rate_quo_d  = rate_quo_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMpc:  mpc_d = cfg_data_i;
        RegApc:  apc_d = cfg_data_i;
        RegNeg:  neg_d = cfg_data_i[0];
        default: ;
      endcase
    end

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          if (opcode_e'(opcode_i) == OP_CLEAR) begin
            prev_l_d = '0;
            prev_r_d = '0;
            x_acc_d  = '0;
            y_acc_d  = '0;
            yaw_d    = '0;
            travel_d = '0;
            dx_d     = '0;
            dy_d     = '0;
            turn_d   = '0;
            zero_d   = 1'b1;
            state_d  = S_DONE;
          end else begin
            prev_l_d    = left_count_i;
            prev_r_d    = right_count_i;
            dt_d        = elapsed_us_i;
            mul_a_d[0]  = {dl[31], dl};
            mul_a_d[1]  = {dr[31], dr};
            mul_a_d[2]  = diff;
            mul_lo_d[0] = mpc_q;
            mul_lo_d[1] = mpc_q;
            mul_lo_d[2] = apc_q;
            for (int l = 0; l < MulLanes; l++) begin
              mul_hi_d[l] = '0;
            end
            state_d = S_MUL;
          end
        end
      end
      S_MUL, S_SCL: begin
        for (int l = 0; l < MulLanes; l++) begin
          mul_hi_d[l] = {mul_sum[l][33], mul_sum[l][33:1]};
          mul_lo_d[l] = {mul_sum[l][0], mul_lo_q[l][31:1]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = (state_q == S_MUL) ? S_PREP : S_STEP;
        end
      end
      S_PREP: begin
        travel_d = sat32({{14{travel_wide[49]}}, travel_wide});
        turn_d   = turn_new;
        flip_d   = phi_flip;
        cx_d     = CordicStart;
        cy_d     = '0;
        cz_d     = {{2{phi_adj[31]}}, phi_adj};
        cnt_d    = '0;
        state_d  = S_ROT;
      end
      S_ROT: begin
        if (cnt_q == '0) begin
          lin_num_d  = lin_prod[50:0];
          rate_num_d = rate_prod[50:16];
          lin_neg_d  = travel_q[31];
          rate_neg_d = turn_q[31];
        end
        if (!cz_q[33]) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - atan;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + atan;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          cnt_d   = '0;
          state_d = S_SLD;
        end
      end
      S_SLD: begin
        mul_a_d[0]  = {travel_q[31], travel_q};
        mul_a_d[1]  = {travel_q[31], travel_q};
        mul_hi_d[0] = '0;
        mul_hi_d[1] = '0;
        mul_lo_d[0] = cx_mag[31:0];
        mul_lo_d[1] = cy_mag[31:0];
        cneg_d      = cx_q[32] ^ flip_q;
        sneg_d      = cy_q[32] ^ flip_q;
        cnt_d       = '0;
        state_d     = S_SCL;
      end
      S_STEP: begin
        dx_d    = sat32({{28{prodx[65]}}, prodx[65:30]});
        dy_d    = sat32({{28{prody[65]}}, prody[65:30]});
        state_d = S_ACC;
      end
      S_ACC: begin
        x_acc_d    = sat32({{31{x_sum[32]}}, x_sum});
        y_acc_d    = sat32({{31{y_sum[32]}}, y_sum});
        yaw_d      = yaw_q + turn_q;
        zero_d     = (dt_q == '0);
        lin_ovf_d  = {13'd0, lin_num_q[50:32]} >= dt_q;
        rate_ovf_d = {29'd0, rate_num_q[34:32]} >= dt_q;
        lin_rem_d  = {13'd0, lin_num_q[50:32]};
        rate_rem_d = {29'd0, rate_num_q[34:32]};
        lin_quo_d  = lin_num_q[31:0];
        rate_quo_d = rate_num_q[31:0];
        cnt_d      = '0;
        state_d    = (dt_q == '0) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        lin_rem_d  = lin_ge ? 32'(lin_r2 - {1'b0, dt_q}) : lin_r2[31:0];
        rate_rem_d = rate_ge ? 32'(rate_r2 - {1'b0, dt_q}) : rate_r2[31:0];
        lin_quo_d  = {lin_quo_q[30:0], lin_ge};
        rate_quo_d = {rate_quo_q[30:0], rate_ge};
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mpc_q       <= 32'd447580;
      apc_q       <= 32'd325268;
      neg_q       <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mpc_q       <= mpc_d;
      apc_q       <= apc_d;
      neg_q       <= neg_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      x_acc_q     <= x_acc_d;
      y_acc_q     <= y_acc_d;
      yaw_q       <= yaw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q       <= dt_d;
    zero_q     <= zero_d;
    mul_a_q    <= mul_a_d;
    mul_hi_q   <= mul_hi_d;
    mul_lo_q   <= mul_lo_d;
    travel_q   <= travel_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    turn_q     <= turn_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    flip_q     <= flip_d;
    cneg_q     <= cneg_d;
    sneg_q     <= sneg_d;
    lin_num_q  <= lin_num_d;
    rate_num_q <= rate_num_d;
    lin_neg_q  <= lin_neg_d;
    rate_neg_q <= rate_neg_d;
    lin_ovf_q  <= lin_ovf_d;
    rate_ovf_q <= rate_ovf_d;
    lin_rem_q  <= lin_rem_d;
    rate_rem_q <= rate_rem_d;
    lin_quo_q  <= lin_quo_d;
    rate_quo_q <= rate_quo_d;
    if (out_load) begin
      pos_x_q    <= x_acc_q;
      pos_y_q    <= y_acc_q;
      heading_q  <= yaw_q;
      travel_o_q <= travel_q;
      dx_o_q     <= dx_q;
      dy_o_q     <= dy_q;
      turn_o_q   <= signed'(turn_q);
      lin_o_q    <= zero_q ? 32'sd0 : div_result(lin_quo_q, lin_neg_q, lin_ovf_q);
      rate_o_q   <= zero_q ? 32'sd0 : div_result(rate_quo_q, rate_neg_q, rate_ovf_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign heading_o      = heading_q;
  assign travel_delta_o = travel_o_q;
  assign step_dx_o      = dx_o_q;
  assign step_dy_o      = dy_o_q;
  assign turn_delta_o   = turn_o_q;
  assign linear_speed_o = lin_o_q;
  assign turn_rate_o    = rate_o_q;

`include "diff_drive_odometry_core_macros.svh"

  `DDO_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "early result")
  `DDO_ASSERT(a_clear_done, clr_acc |=> (state_q == S_DONE && x_acc_q == '0), "pose kept")
  `DDO_ASSERT(a_rot_count, (state_q == S_ROT) |-> (cnt_q < CntW'(CordicSteps)), "rotation overrun")
  `DDO_ASSERT_ALWAYS(a_ready_idle, in_ready_o |-> (state_q == S_IDLE || !rst_ni), "ready while busy")

endmodule

// ===== verif/tb.sv =====
module tb;
  import ddo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    opcode_e     op;
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] dt;
  } sample_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] travel;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] turn;
    logic [31:0] lin;
    logic [31:0] rate;
  } pose_t;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int N_ITEMS     = 1650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [31:0] left_count_i = '0;
  logic [31:0] right_count_i = '0;
  logic [31:0] elapsed_us_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, travel_delta_o, step_dx_o, step_dy_o;
  logic signed [31:0] turn_delta_o, linear_speed_o, turn_rate_o;
  logic [31:0] heading_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  diff_drive_odometry_core u_top (.*);

  // predictor state
  logic [31:0] mpc = 32'd447580;
  logic [31:0] apc = 32'd325268;
  logic        negate = 1'b0;
  logic [31:0] last_left = '0, last_right = '0, yaw = '0;
  logic signed [31:0] x_pos = '0, y_pos = '0;

  sample_t pending_samples[$];
  pose_t   expected_poses[$];
  sample_t cur_item;
  int      errors = 0;
  int      sent = 0;
  int      received = 0;
  int      n_clear = 0;
  int      n_zero_dt = 0;
  int      n_huge = 0;
  int      n_cfg = 0;
  int      burst_left = 1;
  int      gap_left = 0;
  int      stall_left = 0;
  longint  cycles = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tab[i];
  endfunction

  function automatic longint trunc_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    return (num < 0) ? -(mag / den) : (mag / den);
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    logic   flip;
    x = 652032874;
    y = 0;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h8000_0000;
    z = longint'(signed'(ang));
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic apply_cfg(input sample_t smp);
    case (smp.idx)
      RegMpc:  mpc = smp.val;
      RegApc:  apc = smp.val;
      RegNeg:  negate = smp.val[0];
      default: ;
    endcase
  endtask

  task automatic predict_pose(input sample_t smp);
    pose_t  r;
    longint dl, dr, dlq, drq, trav, turn, c, s, dxl, dyl, lin, rate;
    logic [31:0] dlu, dru, t, phi;
    r = '{default: '0};
    if (smp.op == OP_CLEAR) begin
      last_left = '0; last_right = '0; x_pos = '0; y_pos = '0; yaw = '0;
      expected_poses.insert(expected_poses.size(), r);
      return;
    end
    dlu = smp.left - last_left;
    dru = smp.right - last_right;
    dl = longint'(signed'(dlu));
    dr = longint'(signed'(dru));
    last_left = smp.left;
    last_right = smp.right;
    dlq = (dl * longint'(mpc)) >>> 16;
    drq = (dr * longint'(mpc)) >>> 16;
    trav = clamp32((dlq + drq) >>> 1);
    t = 32'((dr - dl) * longint'(apc));
    if (negate) t = 32'd0 - t;
    turn = longint'(signed'(t));
    phi = yaw + 32'(turn >>> 1);
    rotate(phi, c, s);
    dxl = clamp32((trav * c) >>> 30);
    dyl = clamp32((trav * s) >>> 30);
    x_pos = 32'(clamp32(longint'(x_pos) + dxl));
    y_pos = 32'(clamp32(longint'(y_pos) + dyl));
    yaw = yaw + t;
    lin = 0;
    rate = 0;
    if (smp.dt != '0) begin
      lin = trunc_div(trav * 1000000, longint'(smp.dt));
      rate = trunc_div(turn * 1000000, longint'(smp.dt) * 65536);
    end
    r.pos_x = x_pos;
    r.pos_y = y_pos;
    r.heading = yaw;
    r.travel = 32'(trav);
    r.dx = 32'(dxl);
    r.dy = 32'(dyl);
    r.turn = t;
    r.lin = 32'(clamp32(lin));
    r.rate = 32'(clamp32(rate));
    expected_poses.insert(expected_poses.size(), r);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  always @(posedge clk_i) begin : drive_proc
    logic    fire_in, fire_cfg;
    sample_t nxt;
    fire_in  = in_valid_i && in_ready_o;
    fire_cfg = cfg_valid_i && cfg_ready_o;
    if (fire_in) begin
      predict_pose(cur_item);
      sent++;
    end
    if (fire_cfg) begin
      apply_cfg(cur_item);
    end
    if (!rst_ni || (in_valid_i && !fire_in) || (cfg_valid_i && !fire_cfg)) begin
      // hold the waiting transaction
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else if (pending_samples.size() == 0) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else if (pending_samples[0].is_cfg) begin
      in_valid_i <= 1'b0;
      if (sent == received) begin
        nxt = pending_samples.pop_front();
        cur_item = nxt;
        cfg_valid_i <= 1'b1;
        cfg_index_i <= nxt.idx;
        cfg_data_i  <= nxt.val;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end else begin
      nxt = pending_samples.pop_front();
      cur_item = nxt;
      in_valid_i    <= 1'b1;
      cfg_valid_i   <= 1'b0;
      opcode_i      <= nxt.op;
      left_count_i  <= nxt.left;
      right_count_i <= nxt.right;
      elapsed_us_i  <= nxt.dt;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap_left = $urandom_range(0, 30);
      end
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    pose_t got, want;
    if (out_valid_o && out_ready_i) begin
      got.pos_x   = pos_x_o;
      got.pos_y   = pos_y_o;
      got.heading = heading_o;
      got.travel  = travel_delta_o;
      got.dx      = step_dx_o;
      got.dy      = step_dy_o;
      got.turn    = turn_delta_o;
      got.lin     = linear_speed_o;
      got.rate    = turn_rate_o;
      received++;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual pos_x %h", $time, got.pos_x);
      end else begin
        want = expected_poses.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("heading", want.heading, got.heading);
        check_field("travel_delta", want.travel, got.travel);
        check_field("step_dx", want.dx, got.dx);
        check_field("step_dy", want.dy, got.dy);
        check_field("turn_delta", want.turn, got.turn);
        check_field("linear_speed", want.lin, got.lin);
        check_field("turn_rate", want.rate, got.rate);
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 399) == 0) begin
      stall_left = $urandom_range(20, 200);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin : main_proc
    sample_t smp;
    logic [31:0] gl, gr;
    int sel;
    logic timed_out;
    gl = '0;
    gr = '0;
    for (int k = 0; k < N_ITEMS; k++) begin
      if ((k % 200) == 100) begin
        smp.op = OP_UPDATE;
        smp.left = '0;
        smp.right = '0;
        smp.dt = '0;
        smp.is_cfg = 1'b1;
        sel = $urandom_range(0, 2);
        smp.idx = RegMpc;
        smp.val = (sel == 0) ? 32'd447580 :
                  (sel == 1) ? 32'($urandom_range(1, 65535)) : ($urandom | 32'd1);
        pending_samples.insert(pending_samples.size(), smp);
        sel = $urandom_range(0, 2);
        smp.idx = RegApc;
        smp.val = (sel == 0) ? 32'd325268 :
                  (sel == 1) ? 32'($urandom_range(1, 1000)) : ($urandom | 32'd1);
        pending_samples.insert(pending_samples.size(), smp);
        smp.idx = RegNeg;
        smp.val = 32'($urandom_range(0, 1));
        pending_samples.insert(pending_samples.size(), smp);
        n_cfg += 3;
      end
      smp.is_cfg = 1'b0;
      smp.idx = RegMpc;
      smp.val = '0;
      smp.op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_UPDATE;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        gl = $urandom;
        gr = $urandom;
        n_huge++;
      end else if (sel < 4) begin
        gl = gl + $urandom_range(0, 200000) - 32'd100000;
        gr = gr + $urandom_range(0, 200000) - 32'd100000;
      end else begin
        gl = gl + $urandom_range(0, 4000) - 32'd2000;
        gr = gr + $urandom_range(0, 4000) - 32'd2000;
      end
      smp.left = gl;
      smp.right = gr;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        smp.dt = '0;
        n_zero_dt++;
      end else if (sel == 1) begin
        smp.dt = 32'd1;
      end else if (sel == 2) begin
        smp.dt = $urandom;
      end else begin
        smp.dt = $urandom_range(500, 20000);
      end
      if (smp.op == OP_CLEAR) begin
        gl = '0;
        gr = '0;
        n_clear++;
      end
      pending_samples.insert(pending_samples.size(), smp);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while ((received < N_ITEMS) && (cycles < CYCLE_LIMIT)) @(posedge clk_i);
    timed_out = (received < N_ITEMS);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d samples (%0d clears, %0d with zero elapsed time, %0d jumps)",
             N_ITEMS, n_clear, n_zero_dt, n_huge);
    $display("with %0d register writes, bursty input and receiver stalls, in %0d cycles",
             n_cfg, cycles);
    if (!timed_out && errors == 0 && received == N_ITEMS && expected_poses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
